// ----- hdl/dimt_pkg.sv -----
// Shared widths, codes, payload types and control types of the duplicate id merge table.
package dimt_pkg;

  localparam int unsigned MAX_NODES  = 1024;
  localparam int unsigned IDX_W      = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned CNT_W      = $clog2(MAX_NODES + 1);
  localparam int unsigned NODE_IDX_W = 10;
  localparam int unsigned ID_W       = 64;
  localparam int unsigned RES_W      = 32;
  localparam int unsigned ACT_W      = 2;
  localparam int unsigned STAT_W     = 2;
  localparam int unsigned CMP_W      = (CNT_W > NODE_IDX_W) ? CNT_W : NODE_IDX_W;

  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_READ   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] ST_UNLOADED = 2'd2;

  typedef struct packed {
    logic [ACT_W-1:0]      action;
    logic [ID_W-1:0]       node_id;
    logic [RES_W-1:0]      resolution;
    logic [NODE_IDX_W-1:0] node_index;
  } in_item_t;

  typedef struct packed {
    logic [NODE_IDX_W-1:0] original_index;
    logic [RES_W-1:0]      merged_resolution;
    logic [STAT_W-1:0]     status;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_INS_ORG,
    S_INS_RES,
    S_INS_NEW,
    S_RD_ORG,
    S_RD_RES,
    S_FINISH
  } dimt_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic scan_start;
    logic scan_step;
    logic org_rd_idx;
    logic org_rd_hit;
    logic res_rd_org;
    logic ins_merge;
    logic ins_new;
    logic rd_done;
    logic res_full;
    logic res_unloaded;
    logic clear_count;
    logic out_load;
  } dimt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic             full;
    logic             idx_loaded;
    logic             count_zero;
    logic             hit;
    logic             miss_done;
    logic             out_free;
  } dimt_stat_t;

endpackage

// ----- hdl/dimt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module dimt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic                                        re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/dimt_ctrl.sv -----
// Controller state machine that sequences decode, scan, insert or merge, read and result hand-off.
module dimt_ctrl import dimt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  dimt_stat_t stat_i,
  output dimt_cmd_t  cmd_o
);

  dimt_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        priority if (stat_i.action == ACT_INSERT) begin
          priority if (stat_i.full) state_d = S_FINISH;
          else if (stat_i.count_zero) state_d = S_INS_NEW;
          else state_d = S_SCAN;
        end else if (stat_i.action == ACT_READ) begin
          state_d = stat_i.idx_loaded ? S_RD_ORG : S_FINISH;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_SCAN: begin
        priority if (stat_i.hit) state_d = S_INS_ORG;
        else if (stat_i.miss_done) state_d = S_INS_NEW;
        else state_d = S_SCAN;
      end
      S_INS_ORG: state_d = S_INS_RES;
      S_INS_RES: state_d = S_FINISH;
      S_INS_NEW: state_d = S_FINISH;
      S_RD_ORG:  state_d = S_RD_RES;
      S_RD_RES:  state_d = S_FINISH;
      S_FINISH: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.load_item = in_valid_i;
      end
      S_DECODE: begin
        priority if (stat_i.action == ACT_INSERT) begin
          cmd_o.res_full   = stat_i.full;
          cmd_o.scan_start = !stat_i.full && !stat_i.count_zero;
        end else if (stat_i.action == ACT_READ) begin
          cmd_o.org_rd_idx   = stat_i.idx_loaded;
          cmd_o.res_unloaded = !stat_i.idx_loaded;
        end else if (stat_i.action == ACT_CLEAR) begin
          cmd_o.clear_count = 1'b1;
        end else begin
          cmd_o = '0;
        end
      end
      S_SCAN: begin
        cmd_o.org_rd_hit = stat_i.hit;
        cmd_o.scan_step  = !stat_i.hit && !stat_i.miss_done;
      end
      S_INS_ORG: cmd_o.res_rd_org = 1'b1;
      S_INS_RES: cmd_o.ins_merge  = 1'b1;
      S_INS_NEW: cmd_o.ins_new    = 1'b1;
      S_RD_ORG:  cmd_o.res_rd_org = 1'b1;
      S_RD_RES:  cmd_o.rd_done    = 1'b1;
      S_FINISH:  cmd_o.out_load   = stat_i.out_free;
      default:   cmd_o = '0;
    endcase
  end

endmodule

// ----- hdl/dimt_datapath.sv -----
// Datapath: item registers, node count, scan pointer, the three node RAMs and the pending and output result registers.
module dimt_datapath import dimt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  in_item_t   in_data_i,
  input  logic       out_stall_i,
  output logic       out_valid_o,
  output out_item_t  out_data_o,
  input  dimt_cmd_t  cmd_i,
  output dimt_stat_t stat_o
);

  in_item_t         item_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] ptr_q, ptr_d;
  logic             vld_q, vld_d;
  logic [IDX_W-1:0] rd_addr_q, rd_addr_d;
  logic [IDX_W-1:0] org_q;
  out_item_t        pend_q, pend_d;
  out_item_t        out_q;
  logic             out_valid_q, out_valid_d;

  logic [IDX_W-1:0] slot;
  logic [IDX_W-1:0] idx_addr;
  logic             issue;

  logic [ID_W-1:0]  ids_rdata;
  logic [IDX_W-1:0] org_rdata;
  logic [RES_W-1:0] res_rdata;
  logic [RES_W-1:0] res_max;

  logic             ids_we, org_we, org_re, res_we, res_re;
  logic [IDX_W-1:0] org_wdata, org_raddr, res_waddr;
  logic [RES_W-1:0] res_wdata;

  assign slot     = count_q[IDX_W-1:0];
  assign idx_addr = IDX_W'(CMP_W'(item_q.node_index));
  assign issue    = cmd_i.scan_step && (ptr_q < count_q);
  assign res_max  = (item_q.resolution > res_rdata) ? item_q.resolution : res_rdata;

  // Status toward the controller.
  assign stat_o.action     = item_q.action;
  assign stat_o.full       = (count_q == CNT_W'(MAX_NODES));
  assign stat_o.idx_loaded = (CMP_W'(item_q.node_index) < CMP_W'(count_q));
  assign stat_o.count_zero = (count_q == '0);
  assign stat_o.hit        = vld_q && (ids_rdata == item_q.node_id);
  assign stat_o.miss_done  = vld_q && (ids_rdata != item_q.node_id) &&
                             ((CNT_W'(rd_addr_q) + CNT_W'(1)) == count_q);
  assign stat_o.out_free   = !out_valid_q || !out_stall_i;

  // Scan pointer: one identifier read is issued per cycle, compared in the next cycle.
  always_comb begin
    ptr_d     = ptr_q;
    vld_d     = 1'b0;
    rd_addr_d = rd_addr_q;
    if (cmd_i.scan_start) begin
      ptr_d = '0;
    end else if (issue) begin
      ptr_d     = ptr_q + CNT_W'(1);
      vld_d     = 1'b1;
      rd_addr_d = ptr_q[IDX_W-1:0];
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.clear_count) begin
      count_d = '0;
    end else if (cmd_i.ins_merge || cmd_i.ins_new) begin
      count_d = count_q + CNT_W'(1);
    end
  end

  always_comb begin
    pend_d = pend_q;
    if (cmd_i.load_item) begin
      pend_d = '{original_index: '0, merged_resolution: '0, status: ST_OK};
    end
    if (cmd_i.res_full)     pend_d.status = ST_FULL;
    if (cmd_i.res_unloaded) pend_d.status = ST_UNLOADED;
    if (cmd_i.ins_merge)    pend_d.original_index = NODE_IDX_W'(org_q);
    if (cmd_i.ins_new)      pend_d.original_index = NODE_IDX_W'(slot);
    if (cmd_i.rd_done) begin
      pend_d.original_index    = NODE_IDX_W'(org_q);
      pend_d.merged_resolution = res_rdata;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // RAM port selection.
  assign ids_we    = cmd_i.ins_merge || cmd_i.ins_new;
  assign org_we    = cmd_i.ins_merge || cmd_i.ins_new;
  assign org_wdata = cmd_i.ins_merge ? org_q : slot;
  assign org_re    = cmd_i.org_rd_idx || cmd_i.org_rd_hit;
  assign org_raddr = cmd_i.org_rd_hit ? rd_addr_q : idx_addr;
  assign res_we    = cmd_i.ins_merge || cmd_i.ins_new;
  assign res_waddr = cmd_i.ins_merge ? org_q : slot;
  assign res_wdata = cmd_i.ins_merge ? res_max : item_q.resolution;
  assign res_re    = cmd_i.res_rd_org;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ptr_q       <= '0;
      vld_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      ptr_q       <= ptr_d;
      vld_q       <= vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) item_q <= in_data_i;
    if (cmd_i.res_rd_org) org_q <= org_rdata;
    if (cmd_i.out_load) out_q <= pend_q;
    rd_addr_q <= rd_addr_d;
    pend_q    <= pend_d;
  end

  dimt_ram #(.WIDTH(ID_W), .DEPTH(MAX_NODES)) u_ids_ram (
    .clk_i   (clk_i),
    .we_i    (ids_we),
    .waddr_i (slot),
    .wdata_i (item_q.node_id),
    .re_i    (issue),
    .raddr_i (ptr_q[IDX_W-1:0]),
    .rdata_o (ids_rdata)
  );

  dimt_ram #(.WIDTH(IDX_W), .DEPTH(MAX_NODES)) u_org_ram (
    .clk_i   (clk_i),
    .we_i    (org_we),
    .waddr_i (slot),
    .wdata_i (org_wdata),
    .re_i    (org_re),
    .raddr_i (org_raddr),
    .rdata_o (org_rdata)
  );

  dimt_ram #(.WIDTH(RES_W), .DEPTH(MAX_NODES)) u_res_ram (
    .clk_i   (clk_i),
    .we_i    (res_we),
    .waddr_i (res_waddr),
    .wdata_i (res_wdata),
    .re_i    (res_re),
    .raddr_i (org_rdata),
    .rdata_o (res_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- hdl/duplicate_id_merge_table.sv -----
// Duplicate id merge table: top level joining the controller and the datapath.
//
// Input channel (in_valid_i / in_stall_o / in_data_i) carries one transaction per item:
// insert, read or clear. Output channel (out_valid_o / out_stall_i / out_data_o) returns
// exactly one result transaction per item, in order.
// One item is processed at a time; in_stall_o is low only while the block is idle.
// Steps from acceptance to result valid:
//   insert of a new identifier: a linear scan of the identifier RAM, one read per cycle,
//   each compared in the next cycle, then one write (an empty table skips the scan);
//   insert of a duplicate first stored at index k: scan up to index k, origin read,
//   resolution read, merge write; table full: straight to the result;
//   read: origin RAM read, then resolution RAM read; an index that is not loaded, a clear
//   or an unused code goes straight to the result.
// After the result is loaded the block returns to idle before the next item is accepted.
// The identifier scan sets the insert rate.
// Reset clears the node count and the output valid; RAM contents are not cleared,
// since only entries below the node count are ever read.
// A finished result waits in the output register while out_stall_i is high; the block
// then holds the next item's result, with in_stall_o high, until that register frees up.
module duplicate_id_merge_table import dimt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  dimt_cmd_t  cmd;
  dimt_stat_t stat;

  dimt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  dimt_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule
